FILE: hw/rtl/fcmdma_pkg.sv
// Types and constants shared by the four-channel micro DMA controller.
// Depends on nothing.
`default_nettype none
package fcmdma_pkg;

  localparam int unsigned NUM_CH = 4;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_TRIGGER = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_WORD = 2'd1,
    SZ_LONG = 2'd2,
    SZ_NONE = 2'd3
  } size_t;

  localparam logic [2:0] MODE_DST_INC = 3'd0;
  localparam logic [2:0] MODE_DST_DEC = 3'd1;
  localparam logic [2:0] MODE_SRC_INC = 3'd2;
  localparam logic [2:0] MODE_SRC_DEC = 3'd3;
  localparam logic [2:0] MODE_HOLD    = 3'd4;
  localparam logic [2:0] MODE_COUNTER = 3'd5;
  localparam logic [2:0] MODE_BAD6    = 3'd6;
  localparam logic [2:0] MODE_BAD7    = 3'd7;

  localparam logic [7:0] REG_CH_MASK   = 8'hF3;
  localparam logic [7:0] REG_MODE_BASE = 8'h22;
  localparam logic [7:0] REG_CNT_BASE  = 8'h20;
  localparam logic [7:0] REG_LONG_END  = 8'h20;

  localparam logic [4:0] IRQ_BASE   = 5'd14;
  localparam logic [6:0] CLEAR_BASE = 7'h7C;

  // first member in the highest bits
  typedef struct packed {
    logic [6:0]  clear_addr;
    logic [4:0]  irq_source;
    logic        irq_fire;
    logic        bad_mode;
    logic [1:0]  xfer_size;
    logic [31:0] xfer_dst;
    logic [31:0] xfer_src;
    logic        xfer_valid;
    logic        bad_reg;
    logic [31:0] read_data;
  } res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/four_channel_micro_dma_controller.sv
// Four-channel micro DMA controller: register file, trigger step and output skid stage.
// Depends on fcmdma_pkg.
//
// Takes one item per cycle while s_tready is high and returns one registered
// result item per item, in order. Register reads, writes and trigger steps all
// finish in a single pass through a four-entry register file, with a count
// decrement and at most one address update per step. A two-deep output stage
// (result register and skid register) keeps s_tready registered, so the input
// side stalls only when both are full. Reset clears all channel registers to zero.
`default_nettype none
module four_channel_micro_dma_controller (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [47:0]  s_tdata,  // access_size[1:0], reg_addr[9:2], write_data[41:10],
                                      // channel[43:42], zero fill
  input  wire logic [1:0]   s_tuser,  // req_type[1:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [119:0]      m_tdata   // read_data[31:0], bad_reg[32], xfer_valid[33],
                                      // xfer_src[65:34], xfer_dst[97:66], xfer_size[99:98],
                                      // bad_mode[100], irq_fire[101], irq_source[106:102],
                                      // clear_addr[113:107], zero fill
);

  logic [31:0] src_addr [fcmdma_pkg::NUM_CH];
  logic [31:0] dst_addr [fcmdma_pkg::NUM_CH];
  logic [15:0] count    [fcmdma_pkg::NUM_CH];
  logic [7:0]  mode     [fcmdma_pkg::NUM_CH];

  logic [1:0]  req_type;
  logic [1:0]  access_size;
  logic [7:0]  reg_addr;
  logic [31:0] write_data;
  logic [1:0]  channel;

  assign req_type    = s_tuser;
  assign access_size = s_tdata[1:0];
  assign reg_addr    = s_tdata[9:2];
  assign write_data  = s_tdata[41:10];
  assign channel     = s_tdata[43:42];

  logic accept;
  assign accept = s_tvalid && s_tready;

  logic [1:0]  idx;
  logic [31:0] cur_src, cur_dst;
  logic [15:0] cur_cnt;
  logic [7:0]  cur_mode;

  assign idx      = (req_type == fcmdma_pkg::REQ_TRIGGER) ? channel : reg_addr[3:2];
  assign cur_src  = src_addr[idx];
  assign cur_dst  = dst_addr[idx];
  assign cur_cnt  = count[idx];
  assign cur_mode = mode[idx];

  fcmdma_pkg::res_t res;
  logic        wr_src, wr_dst, wr_cnt, wr_mode;
  logic [31:0] src_next, dst_next;
  logic [15:0] cnt_next;
  logic [2:0]  t_mode;
  logic [1:0]  t_size;
  logic [31:0] step;
  logic        hit_mode, hit_cnt, hit_long;

  assign t_mode   = cur_mode[4:2];
  assign t_size   = cur_mode[1:0];
  assign hit_mode = (reg_addr & fcmdma_pkg::REG_CH_MASK) == fcmdma_pkg::REG_MODE_BASE;
  assign hit_cnt  = (reg_addr & fcmdma_pkg::REG_CH_MASK) == fcmdma_pkg::REG_CNT_BASE;
  assign hit_long = (reg_addr < fcmdma_pkg::REG_LONG_END) && (reg_addr[1:0] == 2'b00);

  always_comb begin
    unique case (t_size)
      fcmdma_pkg::SZ_BYTE: step = 32'd1;
      fcmdma_pkg::SZ_WORD: step = 32'd2;
      default:             step = 32'd4;
    endcase
  end

  always_comb begin
    res      = '0;
    wr_src   = 1'b0;
    wr_dst   = 1'b0;
    wr_cnt   = 1'b0;
    wr_mode  = 1'b0;
    src_next = write_data;
    dst_next = write_data;
    cnt_next = write_data[15:0];
    unique case (req_type)
      fcmdma_pkg::REQ_READ, fcmdma_pkg::REQ_WRITE: begin
        unique case (access_size)
          fcmdma_pkg::SZ_BYTE: begin
            if (!hit_mode) begin
              res.bad_reg = 1'b1;
            end else if (req_type == fcmdma_pkg::REQ_WRITE) begin
              wr_mode = 1'b1;
            end else begin
              res.read_data = {24'd0, cur_mode};
            end
          end
          fcmdma_pkg::SZ_WORD: begin
            if (!hit_cnt) begin
              res.bad_reg = 1'b1;
            end else if (req_type == fcmdma_pkg::REQ_WRITE) begin
              wr_cnt = 1'b1;
            end else begin
              res.read_data = {16'd0, cur_cnt};
            end
          end
          fcmdma_pkg::SZ_LONG: begin
            if (!hit_long) begin
              res.bad_reg = 1'b1;
            end else if (req_type == fcmdma_pkg::REQ_WRITE) begin
              wr_src = !reg_addr[4];
              wr_dst = reg_addr[4];
            end else begin
              res.read_data = reg_addr[4] ? cur_dst : cur_src;
            end
          end
          default: res.bad_reg = 1'b1;
        endcase
      end
      fcmdma_pkg::REQ_TRIGGER: begin
        if (cur_cnt != 16'd0) begin
          if (t_mode == fcmdma_pkg::MODE_BAD6 || t_mode == fcmdma_pkg::MODE_BAD7) begin
            res.bad_mode = 1'b1;
          end else begin
            cnt_next = cur_cnt - 16'd1;
            wr_cnt   = 1'b1;
            if (t_mode == fcmdma_pkg::MODE_COUNTER) begin
              src_next = cur_src + 32'd1;
              wr_src   = 1'b1;
            end else if (t_size != fcmdma_pkg::SZ_NONE) begin
              res.xfer_valid = 1'b1;
              res.xfer_src   = cur_src;
              res.xfer_dst   = cur_dst;
              res.xfer_size  = t_size;
              src_next       = (t_mode == fcmdma_pkg::MODE_SRC_DEC) ? cur_src - step
                                                                    : cur_src + step;
              dst_next       = (t_mode == fcmdma_pkg::MODE_DST_DEC) ? cur_dst - step
                                                                    : cur_dst + step;
              wr_src = (t_mode == fcmdma_pkg::MODE_SRC_INC) ||
                       (t_mode == fcmdma_pkg::MODE_SRC_DEC);
              wr_dst = (t_mode == fcmdma_pkg::MODE_DST_INC) ||
                       (t_mode == fcmdma_pkg::MODE_DST_DEC);
            end
            if (cur_cnt == 16'd1) begin
              res.irq_fire   = 1'b1;
              res.irq_source = fcmdma_pkg::IRQ_BASE + {3'd0, channel};
              res.clear_addr = fcmdma_pkg::CLEAR_BASE + {5'd0, channel};
            end
          end
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fcmdma_pkg::NUM_CH; i++) begin
        src_addr[i] <= '0;
        dst_addr[i] <= '0;
        count[i]    <= '0;
        mode[i]     <= '0;
      end
    end else if (accept) begin
      if (wr_src) begin
        src_addr[idx] <= src_next;
      end
      if (wr_dst) begin
        dst_addr[idx] <= dst_next;
      end
      if (wr_cnt) begin
        count[idx] <= cnt_next;
      end
      if (wr_mode) begin
        mode[idx] <= write_data[7:0];
      end
    end
  end

  fcmdma_pkg::res_t out_q, skid_q;
  logic             out_valid, skid_valid;

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (accept) begin
      skid_q <= res;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/dma_step_checker.sv
// Checker for the four-channel micro DMA controller: predicts each result item
// from the accepted input items and compares it with the result side.
// Depends on fcmdma_pkg.
`timescale 1ns / 100ps
module dma_step_checker
  import fcmdma_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [47:0]  s_tdata,
  input  wire logic [1:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [119:0] m_tdata,
  output int                fail_count,
  output int                pending,
  output int                n_copies,
  output int                n_irqs
);

  logic [31:0] src_q  [NUM_CH];
  logic [31:0] dst_q  [NUM_CH];
  logic [15:0] cnt_q  [NUM_CH];
  logic [7:0]  mode_q [NUM_CH];

  res_t expected_results [$];
  res_t want;
  res_t got;

  function automatic res_t dma_step(req_t req, size_t asz, logic [7:0] addr,
                                    logic [31:0] wdata, logic [1:0] ch);
    res_t        res;
    logic        wr;
    logic        known;
    logic [1:0]  idx;
    logic [2:0]  mode;
    size_t       sz;
    logic [31:0] step;
    res   = '0;
    wr    = (req == REQ_WRITE);
    known = 1'b0;
    idx   = addr[3:2];
    case (req)
      REQ_READ, REQ_WRITE: begin
        case (asz)
          SZ_BYTE: begin
            if ((addr & REG_CH_MASK) == REG_MODE_BASE) begin
              known = 1'b1;
              if (wr) mode_q[idx] = wdata[7:0];
              else res.read_data = {24'b0, mode_q[idx]};
            end
          end
          SZ_WORD: begin
            if ((addr & REG_CH_MASK) == REG_CNT_BASE) begin
              known = 1'b1;
              if (wr) cnt_q[idx] = wdata[15:0];
              else res.read_data = {16'b0, cnt_q[idx]};
            end
          end
          SZ_LONG: begin
            if (addr < REG_LONG_END && addr[1:0] == 2'b00) begin
              known = 1'b1;
              if (!addr[4]) begin
                if (wr) src_q[idx] = wdata;
                else res.read_data = src_q[idx];
              end else begin
                if (wr) dst_q[idx] = wdata;
                else res.read_data = dst_q[idx];
              end
            end
          end
          default: known = 1'b0;
        endcase
        res.bad_reg = !known;
      end
      REQ_TRIGGER: begin
        mode = mode_q[ch][4:2];
        sz   = size_t'(mode_q[ch][1:0]);
        step = (sz == SZ_BYTE) ? 32'd1 : (sz == SZ_WORD) ? 32'd2 : 32'd4;
        if (cnt_q[ch] != 16'd0) begin
          if (mode == MODE_BAD6 || mode == MODE_BAD7) begin
            res.bad_mode = 1'b1;
          end else begin
            if (mode == MODE_COUNTER) begin
              src_q[ch] = src_q[ch] + 32'd1;
            end else if (sz != SZ_NONE) begin
              res.xfer_valid = 1'b1;
              res.xfer_src   = src_q[ch];
              res.xfer_dst   = dst_q[ch];
              res.xfer_size  = sz;
              case (mode)
                MODE_DST_INC: dst_q[ch] = dst_q[ch] + step;
                MODE_DST_DEC: dst_q[ch] = dst_q[ch] - step;
                MODE_SRC_INC: src_q[ch] = src_q[ch] + step;
                MODE_SRC_DEC: src_q[ch] = src_q[ch] - step;
                default: ;
              endcase
            end
            cnt_q[ch] = cnt_q[ch] - 16'd1;
            if (cnt_q[ch] == 16'd0) begin
              res.irq_fire   = 1'b1;
              res.irq_source = IRQ_BASE + 5'(ch);
              res.clear_addr = CLEAR_BASE + 7'(ch);
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CH; i++) begin
        src_q[i]  = '0;
        dst_q[i]  = '0;
        cnt_q[i]  = '0;
        mode_q[i] = '0;
      end
      expected_results.delete();
      fail_count = 0;
      pending    = 0;
      n_copies   = 0;
      n_irqs     = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        want = dma_step(req_t'(s_tuser), size_t'(s_tdata[1:0]), s_tdata[9:2],
                        s_tdata[41:10], s_tdata[43:42]);
        if (want.xfer_valid) n_copies++;
        if (want.irq_fire) n_irqs++;
        expected_results.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[113:0];
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result item, expected none, got %0h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("read_data",  want.read_data,  got.read_data);
          check_field("bad_reg",    want.bad_reg,    got.bad_reg);
          check_field("xfer_valid", want.xfer_valid, got.xfer_valid);
          check_field("xfer_src",   want.xfer_src,   got.xfer_src);
          check_field("xfer_dst",   want.xfer_dst,   got.xfer_dst);
          check_field("xfer_size",  want.xfer_size,  got.xfer_size);
          check_field("bad_mode",   want.bad_mode,   got.bad_mode);
          check_field("irq_fire",   want.irq_fire,   got.irq_fire);
          check_field("irq_source", want.irq_source, got.irq_source);
          check_field("clear_addr", want.clear_addr, got.clear_addr);
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// Top of the DMA controller testbench: clock, reset, stimulus and verdict.
// Depends on fcmdma_pkg, dma_step_checker and four_channel_micro_dma_controller.
`timescale 1ns / 100ps
module testbench;
  import fcmdma_pkg::*;

  localparam int         ITEM_TARGET  = 1875;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [7:0] REG_SRC_BASE = 8'h00;
  localparam logic [7:0] REG_DST_BASE = 8'h10;
  localparam int         KIND_SRC     = 0;
  localparam int         KIND_DST     = 1;
  localparam int         KIND_CNT     = 2;
  localparam int         KIND_MODE    = 3;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [119:0] m_tdata;

  int fail_count;
  int pending;
  int n_copies;
  int n_irqs;
  int n_read  = 0;
  int n_write = 0;
  int n_trig  = 0;
  int n_other = 0;
  int cycle_count = 0;
  bit calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_channel_micro_dma_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  dma_step_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_copies   (n_copies),
    .n_irqs     (n_irqs)
  );

  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= 9);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send(req_t req, size_t asz, logic [7:0] addr, logic [31:0] wdata,
                      logic [1:0] ch);
    int gap;
    if (!calm && $urandom_range(0, 99) < 4) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, ch, wdata, addr, asz};
    s_tuser  <= req;
    while (!s_tready) @(negedge clk);
    @(negedge clk);
    case (req)
      REQ_READ:    n_read++;
      REQ_WRITE:   n_write++;
      REQ_TRIGGER: n_trig++;
      default:     n_other++;
    endcase
  endtask

  task automatic reg_io(req_t req, int kind, logic [1:0] ch, logic [31:0] data);
    logic [7:0] sel;
    sel = {4'b0, ch, 2'b00};
    case (kind)
      KIND_SRC: send(req, SZ_LONG, REG_SRC_BASE | sel, data, 2'($urandom_range(0, 3)));
      KIND_DST: send(req, SZ_LONG, REG_DST_BASE | sel, data, 2'($urandom_range(0, 3)));
      KIND_CNT: send(req, SZ_WORD, REG_CNT_BASE | sel, data, 2'($urandom_range(0, 3)));
      default:  send(req, SZ_BYTE, REG_MODE_BASE | sel, data, 2'($urandom_range(0, 3)));
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 3) == 0)
      return ($urandom_range(0, 1) ? 32'hFFFF_FFF0 : 32'h0) | 32'($urandom_range(0, 15));
    return $urandom;
  endfunction

  initial begin : stimulus
    int          r;
    int          kind;
    int          len;
    logic [1:0]  ch;
    logic [2:0]  mode;
    logic [31:0] data;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(REQ_WRITE, SZ_LONG, REG_SRC_BASE, 32'hFFFF_FFFE, 2'd0);
    send(REQ_WRITE, SZ_LONG, REG_DST_BASE, 32'h0000_0001, 2'd0);
    send(REQ_WRITE, SZ_WORD, REG_CNT_BASE, 32'hABCD_0002, 2'd0);
    send(REQ_WRITE, SZ_BYTE, REG_MODE_BASE, {24'hFFFFFF, 3'b111, MODE_DST_INC, SZ_WORD}, 2'd0);
    send(REQ_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd0);
    send(REQ_WRITE, SZ_BYTE, REG_MODE_BASE, {27'b0, MODE_SRC_DEC, SZ_LONG}, 2'd0);
    send(REQ_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd0);
    send(REQ_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd0);
    send(REQ_WRITE, SZ_LONG, REG_SRC_BASE | 8'h0C, 32'hFFFF_FFFF, 2'd3);
    send(REQ_WRITE, SZ_WORD, REG_CNT_BASE | 8'h0C, 32'hFFFF_FFFF, 2'd3);
    send(REQ_WRITE, SZ_BYTE, REG_MODE_BASE | 8'h0C, {27'b0, MODE_SRC_INC, SZ_BYTE}, 2'd3);
    send(REQ_TRIGGER, SZ_NONE, 8'hFF, 32'hFFFF_FFFF, 2'd3);
    send(REQ_WRITE, SZ_BYTE, REG_MODE_BASE | 8'h0C, {27'b0, MODE_COUNTER, SZ_LONG}, 2'd3);
    send(REQ_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd3);
    send(REQ_WRITE, SZ_BYTE, REG_MODE_BASE | 8'h0C, {27'b0, MODE_HOLD, SZ_NONE}, 2'd3);
    send(REQ_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd3);
    send(REQ_WRITE, SZ_BYTE, REG_MODE_BASE | 8'h0C, {27'b0, MODE_BAD6, SZ_BYTE}, 2'd3);
    send(REQ_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd3);
    send(REQ_WRITE, SZ_BYTE, REG_MODE_BASE | 8'h0C, {27'b0, MODE_BAD7, SZ_WORD}, 2'd3);
    send(REQ_TRIGGER, SZ_BYTE, 8'h00, 32'h0, 2'd3);
    send(REQ_READ, SZ_WORD, REG_CNT_BASE | 8'h0C, 32'h0, 2'd0);
    send(REQ_READ, SZ_BYTE, 8'h21, 32'h0, 2'd0);
    send(REQ_WRITE, SZ_WORD, REG_MODE_BASE, 32'h1234_5678, 2'd0);
    send(REQ_READ, SZ_LONG, 8'h02, 32'h0, 2'd0);
    send(REQ_READ, SZ_NONE, REG_SRC_BASE, 32'h0, 2'd0);
    send(REQ_NONE, SZ_LONG, REG_SRC_BASE, 32'hFFFF_FFFF, 2'd2);
    drain();

    while (n_read + n_write + n_trig < ITEM_TARGET) begin
      r    = n_read + n_write + n_trig;
      calm = (r >= 700 && r < 1000);
      if ($urandom_range(0, 299) == 0) drain();
      ch = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 25) begin
        reg_io(REQ_WRITE, KIND_SRC, ch, pick_addr());
        reg_io(REQ_WRITE, KIND_DST, ch, pick_addr());
        mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        data = $urandom;
        data[4:2] = mode;
        reg_io(REQ_WRITE, KIND_MODE, ch, data);
        len  = $urandom_range(1, 6);
        data = $urandom;
        data[15:0] = 16'(len);
        reg_io(REQ_WRITE, KIND_CNT, ch, data);
        for (int i = 0; i <= len; i++) begin
          if ($urandom_range(0, 4) == 0) reg_io(REQ_READ, $urandom_range(0, 3), ch, $urandom);
          send(REQ_TRIGGER, size_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               $urandom, ch);
        end
      end else begin
        r    = $urandom_range(0, 99);
        kind = $urandom_range(0, 3);
        data = $urandom;
        if (r < 35) begin
          send(REQ_TRIGGER, size_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
               data, ch);
        end else if (r < 55) begin
          reg_io(REQ_READ, kind, ch, data);
        end else if (r < 80) begin
          if (kind == KIND_CNT && $urandom_range(0, 9) < 7) data[15:0] = 16'($urandom_range(1, 8));
          reg_io(REQ_WRITE, kind, ch, data);
        end else begin
          send(req_t'($urandom_range(0, 3)), size_t'($urandom_range(0, 3)),
               8'($urandom_range(0, 255)), data, ch);
        end
      end
    end

    calm = 1'b0;
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d reads, %0d writes, %0d triggers and %0d ignored requests.",
             n_read, n_write, n_trig, n_other);
    $display("Predicted %0d copy requests and %0d end-of-count interrupts.", n_copies, n_irqs);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
